@@ rtl/lzssdc_pkg.sv @@
// ----------------------------------------------------------------------------
// LZSS decompressor package
// Shared types and constants for the decompressor and its history window.
// ----------------------------------------------------------------------------
package lzssdc_pkg;

    localparam int WIN_AW    = 12;
    localparam int WIN_DEPTH = 1 << WIN_AW;

    localparam logic [4:0] MIN_MATCH  = 5'd3;
    localparam logic [7:0] PAD_BYTE   = 8'h20;
    localparam logic [3:0] FLAG_EMPTY = 4'd8;
    localparam logic [2:0] TAIL_LEN   = 3'd4;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_SUM_ERR  = 2'd1,
        STAT_DIST_ERR = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_COPY_RD,
        ST_COPY_WAIT,
        ST_EMIT,
        ST_END
    } state_t;

    typedef struct packed {
        logic              wr_en;
        logic [WIN_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [WIN_AW-1:0] rd_addr;
    } win_req_t;

endpackage

@@ rtl/lzss_decompressor_with_sum_check_unit.sv @@
// ----------------------------------------------------------------------------
// LZSS decompressor with sum check
// Packed bytes in on the slave stream, decompressed bytes and a final status
// item out on the master stream.
//
// Input: one packed byte per transfer, tlast on the final byte of a stream.
// The last four bytes of a stream are the little-endian sum of the output.
// Output: tuser=0 carries a data byte; tuser=1 with tlast is the status item
// (0 ok, 1 sum mismatch or sum missing, 2 zero-distance pointer).
// Sequencing: the sequencer handles one input byte at a time and s_axis_tready
// is high only while it waits for input. A byte that yields no output passes
// through decode and end (only end while the delay line fills); a literal
// also passes through the output state and its wait. A pointer copies each
// byte by a window read, a wait for the registered read data and the output
// transfer (a pad byte skips the read and wait); up to 18 bytes per pointer.
// Every output item waits in the output register until the receiver takes it;
// the sequencer stalls meanwhile, so back-pressure holds input too.
// Reset clears all stream state; the window holds no reset and needs no
// clearing pass, since only written positions are ever read. After the
// status item the stream state returns to its reset values.
// ----------------------------------------------------------------------------
module lzss_decompressor_with_sum_check_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [9:8] status, [15:10] zero
    output logic        m_axis_tuser,   // [0] out_kind
    output logic        m_axis_tlast
);
    import lzssdc_pkg::*;

    state_t            state_reg, state_next;
    logic [31:0]       count_reg, count_next;
    logic [31:0]       sum_reg, sum_next;
    logic [31:0]       tail_reg, tail_next;
    logic [2:0]        tail_fill_reg, tail_fill_next;
    logic [7:0]        flag_bits_reg, flag_bits_next;
    logic [3:0]        flag_pos_reg, flag_pos_next;
    logic [7:0]        ptr_low_reg, ptr_low_next;
    logic              ptr_half_reg, ptr_half_next;
    logic              error_reg, error_next;
    logic              last_reg, last_next;
    logic [4:0]        copy_left_reg, copy_left_next;

    logic [7:0]        dec_byte_reg, dec_byte_next;
    logic [WIN_AW-1:0] dist_reg, dist_next;
    logic              out_kind_reg, out_kind_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    status_t           out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;

    logic [WIN_AW-1:0] ptr_dist;
    logic              before_start;
    win_req_t          win_req;
    logic [7:0]        win_rd_data;

    lzssdc_window u_window (
        .clk     (clk),
        .req     (win_req),
        .rd_data (win_rd_data)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign m_axis_tdata  = {6'b0, out_status_reg, out_byte_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    assign ptr_dist     = {dec_byte_reg[7:4], ptr_low_reg};
    assign before_start = (count_reg[31:WIN_AW] == '0) && (count_reg[WIN_AW-1:0] < dist_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        tail_next       = tail_reg;
        tail_fill_next  = tail_fill_reg;
        flag_bits_next  = flag_bits_reg;
        flag_pos_next   = flag_pos_reg;
        ptr_low_next    = ptr_low_reg;
        ptr_half_next   = ptr_half_reg;
        error_next      = error_reg;
        last_next       = last_reg;
        copy_left_next  = copy_left_reg;
        dec_byte_next   = dec_byte_reg;
        dist_next       = dist_reg;
        out_kind_next   = out_kind_reg;
        out_byte_next   = out_byte_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        win_req         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    last_next = s_axis_tlast;
                    tail_next = {s_axis_tdata, tail_reg[31:8]};
                    // the oldest byte of the four-byte delay line is decoded
                    if (tail_fill_reg >= TAIL_LEN)
                    begin
                        dec_byte_next = tail_reg[7:0];
                        state_next    = ST_DECODE;
                    end
                    else
                    begin
                        tail_fill_next = tail_fill_reg + 3'd1;
                        state_next     = ST_END;
                    end
                end
            end

            ST_DECODE:
            begin
                state_next = ST_END;
                if (error_reg)
                begin
                    // data after a zero-distance pointer is dropped
                end
                else if (flag_pos_reg >= FLAG_EMPTY)
                begin
                    flag_bits_next = dec_byte_reg;
                    flag_pos_next  = 4'd0;
                end
                else if (ptr_half_reg)
                begin
                    ptr_half_next = 1'b0;
                    flag_pos_next = flag_pos_reg + 4'd1;
                    if (ptr_dist == '0)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        dist_next      = ptr_dist;
                        copy_left_next = {1'b0, dec_byte_reg[3:0]} + MIN_MATCH;
                        state_next     = ST_COPY_RD;
                    end
                end
                else if (flag_bits_reg[flag_pos_reg[2:0]])
                begin
                    flag_pos_next   = flag_pos_reg + 4'd1;
                    out_kind_next   = KIND_DATA;
                    out_byte_next   = dec_byte_reg;
                    out_status_next = STAT_OK;
                    out_last_next   = 1'b0;
                    copy_left_next  = 5'd1;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    ptr_low_next  = dec_byte_reg;
                    ptr_half_next = 1'b1;
                end
            end

            ST_COPY_RD:
            begin
                out_kind_next   = KIND_DATA;
                out_status_next = STAT_OK;
                out_last_next   = 1'b0;
                if (before_start)
                begin
                    out_byte_next = PAD_BYTE;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    win_req.rd_en   = 1'b1;
                    win_req.rd_addr = count_reg[WIN_AW-1:0] - dist_reg;
                    state_next      = ST_COPY_WAIT;
                end
            end

            ST_COPY_WAIT:
            begin
                out_byte_next = win_rd_data;
                state_next    = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (m_axis_tready)
                begin
                    if (out_kind_reg == KIND_STATUS)
                    begin
                        count_next     = '0;
                        sum_next       = '0;
                        tail_next      = '0;
                        tail_fill_next = '0;
                        flag_bits_next = '0;
                        flag_pos_next  = FLAG_EMPTY;
                        ptr_low_next   = '0;
                        ptr_half_next  = 1'b0;
                        error_next     = 1'b0;
                        last_next      = 1'b0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        win_req.wr_en   = 1'b1;
                        win_req.wr_addr = count_reg[WIN_AW-1:0];
                        win_req.wr_data = out_byte_reg;
                        count_next      = count_reg + 32'd1;
                        sum_next        = sum_reg + {24'd0, out_byte_reg};
                        copy_left_next  = copy_left_reg - 5'd1;
                        state_next      = (copy_left_reg == 5'd1) ? ST_END : ST_COPY_RD;
                    end
                end
            end

            ST_END:
            begin
                if (last_reg)
                begin
                    out_kind_next = KIND_STATUS;
                    out_byte_next = 8'd0;
                    out_last_next = 1'b1;
                    if (error_reg)
                    begin
                        out_status_next = STAT_DIST_ERR;
                    end
                    else if ((tail_fill_reg < TAIL_LEN) || (tail_reg != sum_reg))
                    begin
                        out_status_next = STAT_SUM_ERR;
                    end
                    else
                    begin
                        out_status_next = STAT_OK;
                    end
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            tail_reg      <= '0;
            tail_fill_reg <= '0;
            flag_bits_reg <= '0;
            flag_pos_reg  <= FLAG_EMPTY;
            ptr_low_reg   <= '0;
            ptr_half_reg  <= 1'b0;
            error_reg     <= 1'b0;
            last_reg      <= 1'b0;
            copy_left_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            tail_reg      <= tail_next;
            tail_fill_reg <= tail_fill_next;
            flag_bits_reg <= flag_bits_next;
            flag_pos_reg  <= flag_pos_next;
            ptr_low_reg   <= ptr_low_next;
            ptr_half_reg  <= ptr_half_next;
            error_reg     <= error_next;
            last_reg      <= last_next;
            copy_left_reg <= copy_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dec_byte_reg   <= dec_byte_next;
        dist_reg       <= dist_next;
        out_kind_reg   <= out_kind_next;
        out_byte_reg   <= out_byte_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

endmodule

@@ rtl/lzssdc_window.sv @@
// ----------------------------------------------------------------------------
// LZSS history window
// 4 KiB byte memory, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module lzssdc_window (
    input  logic                clk,
    input  lzssdc_pkg::win_req_t req,
    output logic [7:0]          rd_data
);
    import lzssdc_pkg::*;

    logic [7:0] mem [WIN_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule
